[rtl/crcfr_pkg.sv]
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC-8 byte update for the framed receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

  localparam int unsigned MaxDataDefault = 16;

  localparam logic [7:0]  CrcInit     = 8'hFF;
  localparam logic [7:0]  CrcPoly     = 8'h31;
  localparam logic [7:0]  StartReset  = 8'hA5;
  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [7:0]  LenMin      = 8'd3;
  localparam logic [7:0]  LenHeader   = 8'd5;

  typedef enum logic [0:0] {
    REG_START   = 1'b0,
    REG_TIMEOUT = 1'b1
  } crcfr_reg_e;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_CMD_HI = 6'b000100,
    PH_CMD_LO = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CRC    = 6'b100000
  } crcfr_phase_e;

  typedef struct packed {
    logic        valid;
    logic        bank;
    logic [15:0] cmd;
    logic [7:0]  len;
  } crcfr_job_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/crcfr_store.sv]
// ----------------------------------------------------------------------------
// crcfr_store
// Two-bank payload memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_store #(
  parameter int unsigned MAX_DATA = 16,
  localparam int unsigned Depth  = 2 * MAX_DATA,
  localparam int unsigned ADDR_W = $clog2(Depth)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [7:0]        rd_data_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/crcfr_parser.sv]
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame parser: phase tracking, running CRC-8, inter-byte timeout, payload
// writes into the active bank and hand-off of a checked frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_parser
  import crcfr_pkg::*;
#(
  parameter int unsigned MAX_DATA = 16,
  localparam int unsigned CNT_W  = $clog2(MAX_DATA + 1),
  localparam int unsigned ADDR_W = $clog2(2 * MAX_DATA)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              kind_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic [7:0]        start_marker_i,
  input  wire logic [15:0]       timeout_i,
  input  wire logic              job_busy_i,
  output logic                   in_ready_o,
  output logic                   wr_en_o,
  output logic      [ADDR_W-1:0] wr_addr_o,
  output logic      [7:0]        wr_data_o,
  output crcfr_job_t             job_o
);

  localparam logic [8:0] LenMax = 9'(MAX_DATA + 5);

  crcfr_phase_e     phase_q, phase_d;
  logic [7:0]       len_q, len_d;
  logic [CNT_W-1:0] bif_q, bif_d;
  logic [7:0]       crc_q, crc_d;
  logic [15:0]      cmd_q, cmd_d;
  logic [15:0]      idle_q, idle_d;
  logic             bank_q, bank_d;

  logic             accept;
  logic [15:0]      idle_inc;
  logic [CNT_W-1:0] ndata;
  logic [7:0]       len_sub;
  logic [7:0]       crc_next;
  logic [CNT_W:0]   addr_sum;
  logic [CNT_W:0]   bif_inc;

  assign in_ready_o = !((phase_q == PH_CRC) && job_busy_i);
  assign accept     = in_valid_i && in_ready_o;
  assign idle_inc   = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign len_sub    = len_q - LenHeader;
  assign ndata      = (len_q >= LenHeader) ? CNT_W'(len_sub) : '0;
  assign crc_next   = crc8_byte(crc_q, byte_i);
  assign bif_inc    = {1'b0, bif_q} + (CNT_W + 1)'(1);
  assign addr_sum   = {1'b0, bif_q} + (bank_q ? (CNT_W + 1)'(MAX_DATA) : '0);
  assign wr_addr_o  = addr_sum[ADDR_W-1:0];
  assign wr_data_o  = byte_i;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    bif_d   = bif_q;
    crc_d   = crc_q;
    cmd_d   = cmd_q;
    idle_d  = idle_q;
    bank_d  = bank_q;
    wr_en_o = 1'b0;
    job_o.valid = 1'b0;
    job_o.bank  = bank_q;
    job_o.cmd   = cmd_q;
    job_o.len   = len_q;
    if (accept) begin
      if (kind_i) begin
        if (phase_q != PH_HUNT) begin
          idle_d = idle_inc;
          if (idle_inc >= timeout_i) begin
            phase_d = PH_HUNT;
            bif_d   = '0;
            crc_d   = CrcInit;
            idle_d  = '0;
          end
        end
      end else begin
        idle_d = '0;
        case (phase_q)
          PH_HUNT: begin
            if (byte_i == start_marker_i) begin
              crc_d   = crc8_byte(CrcInit, byte_i);
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if ((byte_i < LenMin) || ({1'b0, byte_i} > LenMax)) begin
              phase_d = PH_HUNT;
              bif_d   = '0;
              crc_d   = CrcInit;
            end else begin
              crc_d   = crc_next;
              len_d   = byte_i;
              cmd_d   = '0;
              bif_d   = '0;
              phase_d = (byte_i >= LenHeader) ? PH_CMD_HI : PH_CRC;
            end
          end
          PH_CMD_HI: begin
            crc_d   = crc_next;
            cmd_d   = {byte_i, 8'h00};
            phase_d = PH_CMD_LO;
          end
          PH_CMD_LO: begin
            crc_d   = crc_next;
            cmd_d   = {cmd_q[15:8], byte_i};
            bif_d   = '0;
            phase_d = (ndata != '0) ? PH_DATA : PH_CRC;
          end
          PH_DATA: begin
            crc_d   = crc_next;
            wr_en_o = 1'b1;
            bif_d   = bif_inc[CNT_W-1:0];
            if (bif_inc >= {1'b0, ndata}) begin
              phase_d = PH_CRC;
            end
          end
          PH_CRC: begin
            if (byte_i == crc_q) begin
              job_o.valid = 1'b1;
              bank_d      = !bank_q;
            end
            phase_d = PH_HUNT;
            bif_d   = '0;
            crc_d   = CrcInit;
          end
          default: begin
            phase_d = PH_HUNT;
            bif_d   = '0;
            crc_d   = CrcInit;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      bif_q   <= '0;
      crc_q   <= CrcInit;
      cmd_q   <= '0;
      idle_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      bif_q   <= bif_d;
      crc_q   <= crc_d;
      cmd_q   <= cmd_d;
      idle_q  <= idle_d;
      bank_q  <= bank_d;
    end
  end

endmodule

`default_nettype wire

[rtl/crcfr_emitter.sv]
// ----------------------------------------------------------------------------
// crcfr_emitter
// Run generator: walks the payload bank of a checked frame and drives the
// result register, one result per cycle unless the output applies backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_emitter
  import crcfr_pkg::*;
#(
  parameter int unsigned MAX_DATA = 16,
  localparam int unsigned CNT_W  = $clog2(MAX_DATA + 1),
  localparam int unsigned ADDR_W = $clog2(2 * MAX_DATA),
  localparam int unsigned EXT_W  = (CNT_W > 4) ? CNT_W : 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire crcfr_job_t        job_i,
  output logic                   busy_o,
  output logic                   rd_en_o,
  output logic      [ADDR_W-1:0] rd_addr_o,
  input  wire logic [7:0]        rd_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [15:0]       cmd_o,
  output logic      [4:0]        len_o,
  output logic      [7:0]        byte_o,
  output logic      [3:0]        idx_o,
  output logic                   present_o,
  output logic                   last_o
);

  logic             active_q;
  logic             bank_q;
  logic [15:0]      cmd_q;
  logic [7:0]       len_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] idx_q;
  logic             empty_q;

  logic             out_valid_q;
  logic [15:0]      out_cmd_q;
  logic [4:0]       out_len_q;
  logic [3:0]       out_idx_q;
  logic             out_present_q;
  logic             out_last_q;

  logic             advance;
  logic [7:0]       job_sub;
  logic [CNT_W-1:0] job_ndata;
  logic [CNT_W:0]   idx_inc;
  logic             at_last;
  logic [CNT_W:0]   addr_sum;
  logic [EXT_W-1:0] idx_ext;

  assign advance   = active_q && (!out_valid_q || out_ready_i);
  assign job_sub   = job_i.len - LenHeader;
  assign job_ndata = (job_i.len >= LenHeader) ? CNT_W'(job_sub) : '0;
  assign idx_inc   = {1'b0, idx_q} + (CNT_W + 1)'(1);
  assign at_last   = (idx_inc == {1'b0, cnt_q});
  assign addr_sum  = {1'b0, idx_q} + (bank_q ? (CNT_W + 1)'(MAX_DATA) : '0);
  assign idx_ext   = EXT_W'(idx_q);

  assign busy_o      = active_q;
  assign rd_en_o     = advance;
  assign rd_addr_o   = addr_sum[ADDR_W-1:0];
  assign out_valid_o = out_valid_q;
  assign cmd_o       = out_cmd_q;
  assign len_o       = out_len_q;
  assign byte_o      = out_present_q ? rd_data_i : 8'h00;
  assign idx_o       = out_idx_q;
  assign present_o   = out_present_q;
  assign last_o      = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_i.valid) begin
        active_q <= 1'b1;
      end else if (advance && at_last) begin
        active_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.valid) begin
      bank_q  <= job_i.bank;
      cmd_q   <= job_i.cmd;
      len_q   <= job_i.len;
      cnt_q   <= (job_ndata == '0) ? CNT_W'(1) : job_ndata;
      empty_q <= (job_ndata == '0);
      idx_q   <= '0;
    end else if (advance) begin
      idx_q <= idx_inc[CNT_W-1:0];
    end
    if (advance) begin
      out_cmd_q     <= cmd_q;
      out_len_q     <= len_q[4:0];
      out_idx_q     <= idx_ext[3:0];
      out_present_q <= !empty_q;
      out_last_q    <= at_last;
    end
  end

endmodule

`default_nettype wire

[rtl/crc8_framed_packet_receiver.sv]
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver
// Takes one byte or tick per cycle; a CRC byte waits while the previous run is
// still being read out of its bank. A good-CRC frame makes the emitter busy,
// which then fills its result register, one result per cycle when not stalled.
// Reset (asynchronous, active low) returns to hunting with default registers.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_framed_packet_receiver
  import crcfr_pkg::*;
#(
  parameter int unsigned MAX_DATA = MaxDataDefault,
  localparam int unsigned ADDR_W = $clog2(2 * MAX_DATA)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  wire logic        s_axis_tuser,   // kind[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // command_word[15:0], frame_len[20:16], payload_byte[28:21],
  // payload_index[32:29], zero fill[39:33]
  output logic      [39:0] m_axis_tdata,
  output logic             m_axis_tuser,   // payload_present[0]
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [7:0]  start_q;
  logic [15:0] timeout_q;
  logic        cfg_wr;
  crcfr_reg_e  cfg_sel;

  crcfr_job_t        job;
  logic              job_busy;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [15:0]       cmd;
  logic [4:0]        len;
  logic [7:0]        pbyte;
  logic [3:0]        pidx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = crcfr_reg_e'(paddr[2]);

  always_comb begin
    case (cfg_sel)
      REG_START:   prdata = {24'h0, start_q};
      REG_TIMEOUT: prdata = {16'h0, timeout_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= StartReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_START:   start_q   <= pwdata[7:0];
        REG_TIMEOUT: timeout_q <= pwdata[15:0];
        default:     start_q   <= start_q;
      endcase
    end
  end

  crcfr_parser #(.MAX_DATA(MAX_DATA)) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .kind_i         (s_axis_tuser),
    .byte_i         (s_axis_tdata),
    .start_marker_i (start_q),
    .timeout_i      (timeout_q),
    .job_busy_i     (job_busy),
    .in_ready_o     (s_axis_tready),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .job_o          (job)
  );

  crcfr_store #(.MAX_DATA(MAX_DATA)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  crcfr_emitter #(.MAX_DATA(MAX_DATA)) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .busy_o      (job_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .len_o       (len),
    .byte_o      (pbyte),
    .idx_o       (pidx),
    .present_o   (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'h00, pidx, pbyte, len, cmd};

endmodule

`default_nettype wire

[rtl/crcfr_checker.sv]
// ----------------------------------------------------------------------------
// crcfr_checker
// Port-level checks on the receiver's result stream and configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast,
  input wire logic        pready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result transaction changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tlast && (m_axis_tdata[28:21] == 8'h00) && (m_axis_tdata[32:29] == 4'h0))
    else $error("empty-frame result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a result run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      (m_axis_tdata[32:29] == $past(m_axis_tdata[32:29]) + 4'd1)
      && ($past(m_axis_tdata[20:0]) == m_axis_tdata[20:0]))
    else $error("result run index or header broken");

  assert property (@(posedge clk_i) pready)
    else $error("pready dropped");

endmodule

bind crc8_framed_packet_receiver crcfr_checker u_crcfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-8 framed packet receiver. Byte and tick
// transactions enter on the input stream; a scoreboard tracks the frame parser
// state and queues the payload results each frame should produce. Directed
// frames cover short, empty and full frames, bad lengths, bad CRC and
// timeouts; random mixes of good and broken frames follow under several
// marker and timeout settings, with random stalls on both streams.
// ----------------------------------------------------------------------------

module tb;
  import crcfr_pkg::*;

  localparam int MaxData    = 16;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    bit [15:0] cmd;
    bit [4:0]  flen;
    bit [7:0]  pbyte;
    bit [3:0]  pidx;
    bit        present;
    bit        last;
  } payload_result_t;

  class crc_frame_scoreboard;
    bit [7:0]        start_marker;
    bit [15:0]       timeout_ticks;
    crcfr_phase_e    phase;
    bit [7:0]        length_seen;
    bit [4:0]        bytes_in_field;
    bit [7:0]        crc;
    bit [15:0]       cmd;
    bit [7:0]        store [MaxData];
    bit [15:0]       idle_ticks;
    payload_result_t payload_due_q[$];
    int              errors;
    int              checked;
    int              predicted;
    int              frames_good;
    int              frames_dropped;

    function new();
      start_marker  = 8'hA5;
      timeout_ticks = 16'd100;
      length_seen   = '0;
      cmd           = '0;
      foreach (store[i]) store[i] = '0;
      rehunt();
    endfunction

    function void rehunt();
      phase          = PH_HUNT;
      bytes_in_field = '0;
      crc            = 8'hFF;
      idle_ticks     = '0;
    endfunction

    function void set_reg(crcfr_reg_e r, bit [31:0] v);
      if (r == REG_START) start_marker = v[7:0];
      else timeout_ticks = v[15:0];
    endfunction

    function bit [7:0] crc_step(bit [7:0] c, bit [7:0] b);
      bit [7:0] x;
      x = c ^ b;
      for (int i = 0; i < 8; i++) begin
        x = x[7] ? ((x << 1) ^ 8'h31) : (x << 1);
      end
      return x;
    endfunction

    function void note_rx_item(bit kind, bit [7:0] b);
      bit [7:0]        ndata;
      int              n;
      payload_result_t res;
      if (kind) begin
        if (phase != PH_HUNT) begin
          if (idle_ticks != 16'hFFFF) idle_ticks++;
          if (idle_ticks >= timeout_ticks) begin
            rehunt();
            frames_dropped++;
          end
        end
        return;
      end
      idle_ticks = '0;
      ndata = (length_seen >= 8'd5) ? length_seen - 8'd5 : 8'd0;
      case (phase)
        PH_HUNT: begin
          if (b == start_marker) begin
            crc   = crc_step(8'hFF, b);
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < 8'd3 || b > MaxData + 5) begin
            rehunt();
            frames_dropped++;
          end else begin
            crc            = crc_step(crc, b);
            length_seen    = b;
            cmd            = '0;
            bytes_in_field = '0;
            phase          = (b >= 8'd5) ? PH_CMD_HI : PH_CRC;
          end
        end
        PH_CMD_HI: begin
          crc   = crc_step(crc, b);
          cmd   = {b, 8'h00};
          phase = PH_CMD_LO;
        end
        PH_CMD_LO: begin
          crc            = crc_step(crc, b);
          cmd[7:0]       = b;
          bytes_in_field = '0;
          phase          = (ndata > 0) ? PH_DATA : PH_CRC;
        end
        PH_DATA: begin
          crc = crc_step(crc, b);
          if (bytes_in_field < MaxData) store[bytes_in_field[3:0]] = b;
          bytes_in_field++;
          if (bytes_in_field >= ndata) phase = PH_CRC;
        end
        PH_CRC: begin
          if (b != crc) begin
            rehunt();
            frames_dropped++;
            return;
          end
          n = (ndata > MaxData) ? MaxData : ndata;
          res.cmd  = cmd;
          res.flen = length_seen[4:0];
          if (n == 0) begin
            res.pbyte   = '0;
            res.pidx    = '0;
            res.present = 1'b0;
            res.last    = 1'b1;
            payload_due_q.push_back(res);
            predicted++;
          end else begin
            for (int k = 0; k < n; k++) begin
              res.pbyte   = store[k];
              res.pidx    = k[3:0];
              res.present = 1'b1;
              res.last    = (k + 1 == n);
              payload_due_q.push_back(res);
              predicted++;
            end
          end
          frames_good++;
          rehunt();
        end
        default: rehunt();
      endcase
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_payload(bit [39:0] word, bit present, bit last);
      payload_result_t want;
      if (payload_due_q.size() == 0) begin
        $display("%0t: payload result with nothing pending, actual tdata %h", $time, word);
        errors++;
        return;
      end
      want = payload_due_q.pop_front();
      cmp_field("command_word", want.cmd, word[15:0]);
      cmp_field("frame_len", want.flen, word[20:16]);
      cmp_field("payload_byte", want.pbyte, word[28:21]);
      cmp_field("payload_index", want.pidx, word[32:29]);
      cmp_field("payload_present", want.present, present);
      cmp_field("end_of_run", want.last, last);
      checked++;
    endfunction

    function int pending();
      return payload_due_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // rx_byte[7:0]
  logic        s_axis_tuser;   // kind[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // command_word[15:0], frame_len[20:16], payload_byte[28:21],
  // payload_index[32:29], zero fill[39:33]
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;   // payload_present[0]
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crc_frame_scoreboard sb;
  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;
  bit long_hold = 1'b0;
  int items_sent = 0;
  int cycles     = 0;

  crc8_framed_packet_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_payload(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // output side stalls
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      gap = rx_calm ? 0 : idle_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input bit kind, input bit [7:0] b);
    int gap;
    gap = tx_calm ? 0 : idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= kind;
    do @(negedge clk_i); while (!s_axis_tready);
    sb.note_rx_item(kind, b);
    items_sent++;
    @(posedge clk_i);
  endtask

  // keep < 0 sends the whole frame, else only its first keep bytes
  task automatic send_frame(input bit [7:0] len, input bit [15:0] cmdw, input int fill,
                            input bit bad_crc, input int keep, input int tick_max);
    bit [7:0] fq[$];
    bit [7:0] c;
    int       nd;
    fq.push_back(sb.start_marker);
    fq.push_back(len);
    if (len >= 5) begin
      fq.push_back(cmdw[15:8]);
      fq.push_back(cmdw[7:0]);
    end
    nd = (len >= 5) ? len - 5 : 0;
    for (int i = 0; i < nd; i++) begin
      case (fill)
        1:       fq.push_back(8'h00);
        2:       fq.push_back(8'hFF);
        3:       fq.push_back(i[0] ? 8'hFF : 8'h00);
        default: fq.push_back(8'($urandom));
      endcase
    end
    c = 8'hFF;
    foreach (fq[i]) c = sb.crc_step(c, fq[i]);
    fq.push_back(bad_crc ? c ^ 8'($urandom_range(1, 255)) : c);
    if (keep >= 0) begin
      while (fq.size() > keep) void'(fq.pop_back());
    end
    foreach (fq[i]) begin
      if (i > 0 && tick_max > 0) begin
        repeat ($urandom_range(0, tick_max)) send_item(1'b1, 8'($urandom));
      end
      send_item(1'b0, fq[i]);
    end
  endtask

  // push the parser back to hunting with bytes that cannot complete a frame
  task automatic resync();
    while (sb.phase != PH_HUNT) begin
      send_item(1'b0, (sb.phase == PH_CRC) ? ~sb.crc : 8'h00);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_check(input crcfr_reg_e r);
    bit [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (r == REG_START) sb.cmp_field("start_marker readback", sb.start_marker, got[7:0]);
    else sb.cmp_field("timeout_ticks readback", sb.timeout_ticks, got[15:0]);
  endtask

  task automatic reg_write(input crcfr_reg_e r, input bit [31:0] v);
    resync();
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk_i);
    reg_check(r);
  endtask

  function automatic bit [7:0] pick_len();
    return 8'(($urandom_range(0, 3) == 0) ? $urandom_range(11, 21) : $urandom_range(3, 10));
  endfunction

  task automatic random_sequence();
    int       r;
    int       tmax;
    int       full;
    bit [7:0] len;
    r   = $urandom_range(0, 99);
    len = pick_len();
    resync();
    if (r < 65) begin
      tmax = 0;
      if (sb.timeout_ticks >= 2 && $urandom_range(0, 3) == 0) begin
        tmax = (sb.timeout_ticks > 3) ? 3 : sb.timeout_ticks - 1;
      end
      send_frame(len, 16'($urandom), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                 1'b0, -1, tmax);
    end else if (r < 75) begin
      send_frame(len, 16'($urandom), 0, 1'b1, -1, 0);
    end else if (r < 82) begin
      send_item(1'b0, sb.start_marker);
      send_item(1'b0, 8'($urandom_range(0, 1) ? $urandom_range(0, 2)
                                               : $urandom_range(22, 255)));
    end else if (r < 90) begin
      full = (len >= 5) ? len + 1 : 3;
      send_frame(len, 16'($urandom), 0, 1'b0, $urandom_range(1, full - 1), 0);
      if (sb.timeout_ticks <= 12) begin
        repeat (sb.timeout_ticks) send_item(1'b1, 8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
    end
  endtask

  initial begin
    bit [7:0]  starts [3];
    bit [15:0] touts [3];
    int        base_items;
    int        base_results;
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_check(REG_START);
    reg_check(REG_TIMEOUT);

    // ticks while hunting, short, empty and full frames, broken frames
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);
    send_frame(3, 16'h0000, 0, 1'b0, -1, 0);
    send_frame(4, 16'h0000, 0, 1'b0, -1, 0);
    send_frame(5, 16'hFFFF, 0, 1'b0, -1, 0);
    send_item(1'b0, sb.start_marker);
    send_item(1'b0, 8'd2);
    send_item(1'b0, sb.start_marker);
    send_item(1'b0, 8'd22);
    send_frame(3, 16'h0000, 0, 1'b1, -1, 0);
    send_frame(21, 16'h0000, 3, 1'b0, -1, 0);

    // timeouts at the low extremes, then tick runs under the top timeout
    reg_write(REG_START, 32'h00);
    reg_write(REG_TIMEOUT, 32'd1);
    send_frame(5, 16'($urandom), 0, 1'b0, -1, 0);
    send_frame(8, 16'($urandom), 0, 1'b0, 2, 0);
    send_item(1'b1, 8'($urandom));
    reg_write(REG_TIMEOUT, 32'd0);
    send_frame(10, 16'($urandom), 0, 1'b0, 4, 0);
    send_item(1'b1, 8'($urandom));
    reg_write(REG_TIMEOUT, 32'hFFFF);
    reg_write(REG_START, 32'hFF);
    send_frame(6, 16'($urandom), 0, 1'b0, -1, 4);

    starts = '{8'h3C, 8'($urandom), 8'hA5};
    touts  = '{16'd4, 16'($urandom_range(2, 12)), 16'd100};
    for (int p = 0; p < 3; p++) begin
      reg_write(REG_START, 32'(starts[p]));
      reg_write(REG_TIMEOUT, 32'(touts[p]));
      tx_calm      = (p == 1);
      rx_calm      = (p == 1);
      base_items   = items_sent;
      base_results = sb.predicted;
      while (items_sent - base_items < 10 || sb.predicted - base_results < 3) begin
        random_sequence();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // hold the output off while frames keep arriving
    resync();
    s_axis_tvalid <= 1'b0;
    long_hold = 1'b1;
    wait (long_hold == 1'b0);
    tx_calm = 1'b1;
    repeat (2) send_frame(13, 16'($urandom), 0, 1'b0, -1, 0);
    tx_calm = 1'b0;
    wait_drained();
    repeat (2) random_sequence();

    resync();
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("run: %0d byte/tick transactions, %0d frames accepted, %0d frames dropped",
             items_sent, sb.frames_good, sb.frames_dropped);
    $display("run: %0d payload results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/crcfr_pkg.sv
rtl/crcfr_store.sv
rtl/crcfr_parser.sv
rtl/crcfr_emitter.sv
rtl/crc8_framed_packet_receiver.sv
rtl/crcfr_checker.sv
sim/tb.sv
